>>> design/shpd_pkg.sv
// Package: shared constants and types of the script height push decoder.
`default_nettype none

package shpd_pkg;

  localparam int unsigned WindowBytes = 8;
  localparam int unsigned HeightW     = 32;

  localparam logic [7:0] OpZero      = 8'h00;
  localparam logic [7:0] OpNegOne    = 8'h4f;
  localparam logic [7:0] OpSmallLo   = 8'h51;
  localparam logic [7:0] OpSmallHi   = 8'h60;
  localparam logic [7:0] OpPushData1 = 8'h4c;
  localparam logic [7:0] OpPushData2 = 8'h4d;
  localparam logic [7:0] OpPushData4 = 8'h4e;
  localparam logic [7:0] SmallBias   = 8'h50;

  typedef struct packed {
    logic signed [HeightW-1:0] height;
    logic                      bad_opcode;
  } result_t;

endpackage

`default_nettype wire

>>> design/shpd_chan_if.sv
// Interfaces: valid/ready channels for input bytes and decoded results.
`default_nettype none

interface shpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface shpd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [shpd_pkg::HeightW-1:0] height;
  logic                               bad_opcode;

  modport source (output valid, output height, output bad_opcode, input ready);
  modport sink (input valid, input height, input bad_opcode, output ready);
endinterface

`default_nettype wire

>>> design/shpd_core.sv
// Core: push parser state and window decode, one byte per step.
`default_nettype none

module shpd_core #(
  parameter int unsigned WindowBytes = shpd_pkg::WindowBytes
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       data_byte_i,
  output logic                  res_valid_o,
  output shpd_pkg::result_t     res_o
);

  localparam int unsigned WinW  = 8 * WindowBytes;
  localparam int unsigned HeldW = $clog2(WindowBytes + 1);
  localparam int unsigned BitW  = $clog2(WinW);
  localparam logic [HeldW-1:0] FullHeld = HeldW'(WindowBytes);

  typedef enum logic [2:0] {
    PhOpcode,
    PhLen1,
    PhLen2,
    PhLen4,
    PhData
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [2:0]       len_left_q, len_left_d;
  logic [31:0]      data_left_q, data_left_d;
  logic [WinW-1:0]  window_q, window_d;
  logic [HeldW-1:0] held_q, held_d;

  logic [WinW-1:0]  window_shift;
  logic [HeldW-1:0] held_inc;
  logic [WinW-1:0]  mag_all;
  logic [BitW-1:0]  sign_idx;
  logic             neg;
  logic [WinW-1:0]  mag_clr;
  logic [63:0]      mag_ext;
  logic [31:0]      mag_lo;
  logic [31:0]      height_dec;
  logic [2:0]       len_total;
  logic [2:0]       len_cur;
  logic [2:0]       len_next;
  logic [1:0]       len_idx;
  logic [31:0]      data_or;
  logic             is_small;
  logic [31:0]      small_val;

  always_comb begin
    window_shift = WinW'({data_byte_i, window_q} >> 8);
    held_inc     = (held_q < FullHeld) ? HeldW'(held_q + 1'b1) : held_q;
    mag_all      = window_shift >> {(FullHeld - held_inc), 3'b000};
    sign_idx     = BitW'({held_inc, 3'b000} - 1'b1);
    neg          = mag_all[sign_idx];
    mag_clr      = mag_all & ~(WinW'(1) << sign_idx);
    mag_ext      = 64'(mag_clr);
    mag_lo       = mag_ext[31:0];
    height_dec   = neg ? (32'd0 - mag_lo) : mag_lo;

    case (phase_q)
      PhLen1:  len_total = 3'd1;
      PhLen2:  len_total = 3'd2;
      default: len_total = 3'd4;
    endcase
    len_cur  = (len_left_q == 3'd0 || len_left_q > len_total) ? len_total : len_left_q;
    len_idx  = 2'(len_total - len_cur);
    len_next = len_cur - 3'd1;
    data_or  = data_left_q | (32'(data_byte_i) << {len_idx, 3'b000});

    is_small  = (data_byte_i == shpd_pkg::OpNegOne) ||
                (data_byte_i >= shpd_pkg::OpSmallLo && data_byte_i <= shpd_pkg::OpSmallHi);
    small_val = 32'(data_byte_i) - 32'(shpd_pkg::SmallBias);
  end

  always_comb begin
    phase_d     = phase_q;
    len_left_d  = len_left_q;
    data_left_d = data_left_q;
    window_d    = window_q;
    held_d      = held_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      case (phase_q)
        PhOpcode: begin
          if (data_byte_i == shpd_pkg::OpZero) begin
            res_valid_o = 1'b1;
          end else if (is_small) begin
            res_valid_o  = 1'b1;
            res_o.height = small_val;
          end else begin
            window_d    = '0;
            held_d      = '0;
            data_left_d = '0;
            if (data_byte_i < shpd_pkg::OpPushData1) begin
              data_left_d = 32'(data_byte_i);
              phase_d     = PhData;
            end else if (data_byte_i == shpd_pkg::OpPushData1) begin
              phase_d    = PhLen1;
              len_left_d = 3'd1;
            end else if (data_byte_i == shpd_pkg::OpPushData2) begin
              phase_d    = PhLen2;
              len_left_d = 3'd2;
            end else if (data_byte_i == shpd_pkg::OpPushData4) begin
              phase_d    = PhLen4;
              len_left_d = 3'd4;
            end else begin
              res_valid_o      = 1'b1;
              res_o.bad_opcode = 1'b1;
              len_left_d       = '0;
            end
          end
        end
        PhLen1, PhLen2, PhLen4: begin
          data_left_d = data_or;
          len_left_d  = len_next;
          if (len_next == 3'd0) begin
            if (data_or == 32'd0) begin
              res_valid_o = 1'b1;
              phase_d     = PhOpcode;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          if (data_left_q != 32'd0) begin
            window_d    = window_shift;
            held_d      = held_inc;
            data_left_d = data_left_q - 32'd1;
            if (data_left_q == 32'd1) begin
              res_valid_o  = 1'b1;
              res_o.height = height_dec;
              phase_d      = PhOpcode;
              len_left_d   = '0;
            end
          end else begin
            phase_d     = PhOpcode;
            len_left_d  = '0;
            data_left_d = '0;
            window_d    = '0;
            held_d      = '0;
          end
        end
        default: begin
          phase_d     = PhOpcode;
          len_left_d  = '0;
          data_left_d = '0;
          window_d    = '0;
          held_d      = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhOpcode;
      len_left_q  <= '0;
      data_left_q <= '0;
      window_q    <= '0;
      held_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      data_left_q <= data_left_d;
      window_q    <= window_d;
      held_q      <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> design/script_height_push_decoder.sv
// Top level: script height push decoder with a two-word result buffer.
`default_nettype none

// Decodes one script number push fed as a byte stream, opcode byte first, and
// returns one word (height, bad_opcode) per completed push: immediately for
// opcode 0, 0x4f and 0x51..0x60 and for invalid opcodes, after the last length
// byte for a zero PUSHDATA length, and after the last data byte otherwise.
// One byte per cycle is sustained while the skid word is empty; the parser
// state updates in a single step and the result lands in a two-word output
// buffer, so in_i.ready drops only while both buffer words are waiting on
// out_o.ready. Each result is registered into the main or the skid word.

module script_height_push_decoder #(
  parameter int unsigned WindowBytes = shpd_pkg::WindowBytes
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  shpd_in_if.sink      in_i,
  shpd_out_if.source   out_o
);

  logic              step;
  logic              res_valid;
  shpd_pkg::result_t res;

  logic              main_valid_q;
  logic              skid_valid_q;
  shpd_pkg::result_t main_q;
  shpd_pkg::result_t skid_q;
  logic              push;
  logic              pop;

  assign in_i.ready = !skid_valid_q;
  assign step       = in_i.valid && in_i.ready;

  shpd_core #(
    .WindowBytes (WindowBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_i.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign push = step && res_valid;
  assign pop  = main_valid_q && out_o.ready;

  assign out_o.valid      = main_valid_q;
  assign out_o.height     = main_q.height;
  assign out_o.bad_opcode = main_q.bad_opcode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push) begin
      if (main_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid word held without a main word");

  a_bad_height_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_opcode) |-> (out_o.height == '0))
    else $error("bad opcode word carries a nonzero height");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && main_valid_q && !out_o.ready) |=> skid_valid_q)
    else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

>>> tb/script_height_push_decoder_chk.sv
// Checker: watches both channels, predicts each decoded height and compares it with the block.
`default_nettype none

module script_height_push_decoder_chk (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  shpd_in_if        byte_i,
  shpd_out_if       height_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    AwaitOp,
    LenBytes1,
    LenBytes2,
    LenBytes4,
    DataBytes
  } push_phase_e;

  push_phase_e         phase;
  logic [2:0]          len_left;
  logic [31:0]         data_left;
  logic [63:0]         window;
  logic [3:0]          held;
  shpd_pkg::result_t   heights_due[$];
  int                  mismatches = 0;

  assign fail_count_o = mismatches;

  task report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function void clear_push();
    phase     = AwaitOp;
    len_left  = '0;
    data_left = '0;
    window    = '0;
    held      = '0;
  endfunction

  function void settle(input logic signed [shpd_pkg::HeightW-1:0] h, input logic bad);
    shpd_pkg::result_t due;
    due.height     = h;
    due.bad_opcode = bad;
    heights_due.insert(heights_due.size(), due);
    phase     = AwaitOp;
    len_left  = '0;
    data_left = '0;
  endfunction

  function logic [shpd_pkg::HeightW-1:0] window_value();
    int unsigned kept;
    logic [63:0] mag;
    logic [63:0] sign_bit;
    logic        neg;
    kept = (held > shpd_pkg::WindowBytes) ? shpd_pkg::WindowBytes : held;
    if (kept == 0) return '0;
    mag      = window >> (8 * (shpd_pkg::WindowBytes - kept));
    sign_bit = 64'h80 << (8 * (kept - 1));
    neg      = (mag & sign_bit) != 0;
    mag      = mag & ~sign_bit;
    if (neg) mag = 64'd0 - mag;
    return mag[shpd_pkg::HeightW-1:0];
  endfunction

  function void take_byte(input logic [7:0] b);
    int unsigned total;
    int unsigned idx;
    case (phase)
      AwaitOp: begin
        if (b == shpd_pkg::OpZero) begin
          settle('0, 1'b0);
        end else if (b == shpd_pkg::OpNegOne ||
                     (b >= shpd_pkg::OpSmallLo && b <= shpd_pkg::OpSmallHi)) begin
          settle(32'(b) - 32'(shpd_pkg::SmallBias), 1'b0);
        end else begin
          window    = '0;
          held      = '0;
          data_left = '0;
          if (b < shpd_pkg::OpPushData1) begin
            data_left = 32'(b);
            phase     = DataBytes;
          end else if (b == shpd_pkg::OpPushData1) begin
            phase    = LenBytes1;
            len_left = 3'd1;
          end else if (b == shpd_pkg::OpPushData2) begin
            phase    = LenBytes2;
            len_left = 3'd2;
          end else if (b == shpd_pkg::OpPushData4) begin
            phase    = LenBytes4;
            len_left = 3'd4;
          end else begin
            settle('0, 1'b1);
          end
        end
      end
      LenBytes1, LenBytes2, LenBytes4: begin
        total = (phase == LenBytes1) ? 1 : (phase == LenBytes2) ? 2 : 4;
        if (len_left == 0 || len_left > total) len_left = 3'(total);
        idx = total - len_left;
        data_left = data_left | (32'(b) << (8 * idx));
        len_left--;
        if (len_left == 0) begin
          if (data_left == 0) settle('0, 1'b0);
          else phase = DataBytes;
        end
      end
      DataBytes: begin
        if (data_left != 0) begin
          window = {b, window[63:8]};
          if (held < shpd_pkg::WindowBytes) held++;
          data_left--;
          if (data_left == 0) settle(window_value(), 1'b0);
        end else begin
          clear_push();
        end
      end
      default: clear_push();
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    shpd_pkg::result_t due;
    if (!rst_ni) begin
      clear_push();
      heights_due.delete();
      pending_o <= 0;
    end else begin
      if (byte_i.valid && byte_i.ready) take_byte(byte_i.data_byte);
      if (height_i.valid && height_i.ready) begin
        if (heights_due.size() == 0) begin
          report($sformatf("unexpected word height=%0d bad_opcode=%0b",
                           height_i.height, height_i.bad_opcode));
        end else begin
          due = heights_due.pop_front();
          if (height_i.height !== due.height)
            report($sformatf("height got %0d want %0d", height_i.height, due.height));
          if (height_i.bad_opcode !== due.bad_opcode)
            report($sformatf("bad_opcode got %0b want %0b",
                             height_i.bad_opcode, due.bad_opcode));
        end
      end
      pending_o <= heights_due.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/script_height_push_decoder_tb.sv
// Testbench top: clock, reset, byte stimulus and result back-pressure around the decoder.
`default_nettype none

module script_height_push_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomBytes = 1850;
  localparam int unsigned CalmFrom    = 700;
  localparam int unsigned CalmTo      = 1000;
  localparam int unsigned DrainAt     = 1200;
  localparam logic [7:0]  OpBadLow    = 8'h50;
  localparam logic [7:0]  OpBadTop    = 8'hff;

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  int          fail_count;
  int          pending;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  logic [7:0]  body[$];

  shpd_in_if  byte_ch ();
  shpd_out_if height_ch ();

  script_height_push_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (height_ch)
  );

  script_height_push_decoder_chk chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_ch),
    .height_i     (height_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial height_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    height_ch.ready <= calm || ($urandom_range(99) >= 35);
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 35) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(negedge clk_i); while (!byte_ch.ready);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_push(input logic [7:0] op, input logic [31:0] len);
    logic [31:0] count;
    logic [31:0] k;
    send_byte(op);
    count = '0;
    if (op != shpd_pkg::OpZero && op < shpd_pkg::OpPushData1) begin
      count = 32'(op);
    end else if (op == shpd_pkg::OpPushData1) begin
      send_byte(len[7:0]);
      count = 32'(len[7:0]);
    end else if (op == shpd_pkg::OpPushData2) begin
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      count = 32'(len[15:0]);
    end else if (op == shpd_pkg::OpPushData4) begin
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      send_byte(len[23:16]);
      send_byte(len[31:24]);
      count = len;
    end
    for (k = 0; k < count; k++) begin
      send_byte(body.size() != 0 ? body.pop_front() : 8'($urandom));
    end
    body.delete();
  endtask

  function automatic logic [31:0] push_len(input bit allow_big);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 80) return 32'($urandom_range(1, 9));
    if (r < 96) return 32'($urandom_range(10, 80));
    return allow_big ? 32'($urandom_range(200, 600)) : 32'($urandom_range(10, 255));
  endfunction

  initial begin : stimulus
    int unsigned r;
    int unsigned pick;
    int unsigned start_count;
    bit          drained;
    logic [7:0]  op;
    rst_ni            = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    calm              = 1'b0;
    bytes_sent        = 0;
    drained           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_push(shpd_pkg::OpZero, '0);
    send_push(shpd_pkg::OpNegOne, '0);
    send_push(shpd_pkg::OpSmallLo, '0);
    send_push(shpd_pkg::OpSmallHi, '0);
    send_push(OpBadLow, '0);
    send_push(OpBadTop, '0);
    body.insert(body.size(), 8'h80);
    send_push(8'd1, '0);
    send_push(shpd_pkg::OpPushData1, '0);
    send_push(shpd_pkg::OpPushData4, '0);
    repeat (8) body.insert(body.size(), 8'hff);
    send_push(8'd8, '0);

    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomBytes) begin
      calm <= (bytes_sent - start_count >= CalmFrom) && (bytes_sent - start_count < CalmTo);
      if (!drained && bytes_sent - start_count >= DrainAt) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 40) begin
        op = ($urandom_range(99) < 70) ? 8'($urandom_range(1, 9)) : 8'($urandom_range(1, 75));
        send_push(op, '0);
      end else if (r < 55) begin
        pick = $urandom_range(17);
        if (pick == 0) op = shpd_pkg::OpNegOne;
        else if (pick == 17) op = shpd_pkg::OpZero;
        else op = shpd_pkg::OpSmallLo + 8'(pick - 1);
        send_push(op, '0);
      end else if (r < 80) begin
        pick = $urandom_range(2);
        op = (pick == 0) ? shpd_pkg::OpPushData1 :
             (pick == 1) ? shpd_pkg::OpPushData2 : shpd_pkg::OpPushData4;
        send_push(op, push_len(pick != 0));
      end else begin
        send_push(8'($urandom_range(255)), push_len(1'b1));
      end
    end

    byte_ch.valid <= 1'b0;
    calm          <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/shpd_pkg.sv
design/shpd_chan_if.sv
design/shpd_core.sv
design/script_height_push_decoder.sv
tb/script_height_push_decoder_chk.sv
tb/script_height_push_decoder_tb.sv
